[hw/rtl/mmba_pkg.sv]
package mmba_pkg;

   localparam int ADDR_W        = 64;
   localparam int KIND_W        = 32;
   localparam int ATTR_W        = 32;
   localparam int OPCODE_W      = 2;
   localparam int ENTRY_IDX_W   = 5;
   localparam int COUNT_W       = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 1;
   localparam int MAP_DEPTH_DEFAULT = 32;

   // map entry as stored in RAM: {usable, length, base}
   localparam int ENTRY_W = 2 * ADDR_W + 1;

   localparam logic [ADDR_W-1:0] PAGE_SIZE   = 64'h1000;
   localparam logic [ADDR_W-1:0] ALLOC_ALIGN = 64'd64;
   localparam logic [KIND_W-1:0] KIND_USABLE = 32'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_ENTRY = 2'd0,
      OP_INIT_PTR    = 2'd1,
      OP_ALLOC       = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_END  = 1'd0,
      CSR_ENTRY_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   typedef struct packed {
      logic wr_entry;   // store a map entry
      logic init_ptr;   // load pointer from kernel end
      logic latch_req;  // capture rounded size and scan limit
      logic rd_en;      // read one map entry
      logic eval;       // read data valid, test the entry
      logic commit;     // load output word, advance pointer on grant
   } cmd_type;

   typedef struct packed {
      logic hit;        // entry under test can hold the block
   } status_type;

endpackage

[hw/rtl/mmba_if.sv]
interface mmba_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [mmba_pkg::OPCODE_W-1:0]          opcode;
   logic [mmba_pkg::ENTRY_IDX_W-1:0]       entry_index;
   logic [mmba_pkg::ADDR_W-1:0]            region_base;
   logic [mmba_pkg::ADDR_W-1:0]            region_length;
   logic [mmba_pkg::KIND_W-1:0]            region_kind;
   logic [mmba_pkg::ATTR_W-1:0]            region_attributes;
   logic [mmba_pkg::ADDR_W-1:0]            request_size;

   modport source (
      output valid, opcode, entry_index, region_base, region_length,
             region_kind, region_attributes, request_size,
      input  ready
   );
   modport sink (
      input  valid, opcode, entry_index, region_base, region_length,
             region_kind, region_attributes, request_size,
      output ready
   );
endinterface

interface mmba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mmba_pkg::ADDR_W-1:0]  alloc_address;
   logic                         alloc_failed;

   modport source (
      output valid, alloc_address, alloc_failed,
      input  ready
   );
   modport sink (
      input  valid, alloc_address, alloc_failed,
      output ready
   );
endinterface

[hw/rtl/mmba_ram.sv]
module mmba_ram #(
   parameter int WIDTH = mmba_pkg::ENTRY_W,
   parameter int DEPTH = mmba_pkg::MAP_DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mmba_ctrl.sv]
module mmba_ctrl #(
   parameter int MAP_DEPTH = mmba_pkg::MAP_DEPTH_DEFAULT,
   localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
   localparam int CW = $clog2(MAP_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mmba_pkg::OPCODE_W-1:0] req_opcode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [CW-1:0]                 scan_limit,
   input  mmba_pkg::status_type          status,
   output mmba_pkg::cmd_type             cmd,
   output logic [AW-1:0]                 rd_addr
);

   mmba_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                more;

   assign req_ready = (state_ff == mmba_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign more      = (idx_ff < scan_limit);
   assign rd_addr   = idx_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         mmba_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  mmba_pkg::OP_WRITE_ENTRY: cmd.wr_entry = 1'b1;
                  mmba_pkg::OP_INIT_PTR:    cmd.init_ptr = 1'b1;
                  mmba_pkg::OP_ALLOC: begin
                     cmd.latch_req = 1'b1;
                     idx_in        = '0;
                     state_in      = mmba_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         mmba_pkg::ST_SCAN: begin
            cmd.rd_en   = more;
            cmd.eval    = rd_valid_ff;
            rd_valid_in = more;
            if (more) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_valid_ff && status.hit) begin
               state_in = mmba_pkg::ST_RESULT;
            end else if (!more && !rd_valid_ff) begin
               state_in = mmba_pkg::ST_RESULT;
            end
         end
         mmba_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mmba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmba_pkg::ST_IDLE;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/mmba_dp.sv]
module mmba_dp #(
   parameter int MAP_DEPTH = mmba_pkg::MAP_DEPTH_DEFAULT,
   localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
   localparam int CW = $clog2(MAP_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mmba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mmba_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic [mmba_pkg::ENTRY_IDX_W-1:0]  req_entry_index,
   input  logic [mmba_pkg::ADDR_W-1:0]       req_region_base,
   input  logic [mmba_pkg::ADDR_W-1:0]       req_region_length,
   input  logic [mmba_pkg::KIND_W-1:0]       req_region_kind,
   input  logic [mmba_pkg::ATTR_W-1:0]       req_region_attributes,
   input  logic [mmba_pkg::ADDR_W-1:0]       req_request_size,
   input  mmba_pkg::cmd_type                 cmd,
   input  logic [AW-1:0]                     rd_addr,
   output mmba_pkg::status_type              status,
   output logic [CW-1:0]                     scan_limit,
   output logic [mmba_pkg::ADDR_W-1:0]       rsp_alloc_address,
   output logic                              rsp_alloc_failed
);

   localparam int W = mmba_pkg::ADDR_W;

   logic [W-1:0]                      kend_ff;
   logic [mmba_pkg::COUNT_W-1:0]      count_ff;
   logic [W-1:0]                      ptr_ff, ptr_in;
   logic [W-1:0]                      size_ff;
   logic [CW-1:0]                     limit_ff;
   logic [W:0]                        ptr_need_ff;
   logic [W-1:0]                      grant_ff;
   logic                              hit_ff;
   logic [W-1:0]                      out_addr_ff;
   logic                              out_failed_ff;

   logic                              wr_en;
   logic                              usable_in;
   logic [mmba_pkg::ENTRY_W-1:0]      rd_data;
   logic [W:0]                        size_sum;
   logic [W-1:0]                      init_sum;
   logic [CW-1:0]                     limit_clamp;

   logic [W-1:0]                      e_base, e_len;
   logic                              e_usable;
   logic [W:0]                        e_end, e_base_need;
   logic                              ptr_ge;
   logic                              fits;

   // opcode 0 writes only slots that exist
   assign wr_en     = cmd.wr_entry && (32'(req_entry_index) < 32'(MAP_DEPTH));
   assign usable_in = (req_region_kind == mmba_pkg::KIND_USABLE) && req_region_attributes[0];

   mmba_ram #(
      .WIDTH (mmba_pkg::ENTRY_W),
      .DEPTH (MAP_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({usable_in, req_region_length, req_region_base}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign size_sum = {1'b0, req_request_size} + {1'b0, mmba_pkg::ALLOC_ALIGN - W'(1)};
   assign init_sum = kend_ff + mmba_pkg::PAGE_SIZE + (mmba_pkg::PAGE_SIZE - W'(1));

   always_comb begin
      if (32'(count_ff) > 32'(MAP_DEPTH)) begin
         limit_clamp = CW'(MAP_DEPTH);
      end else begin
         limit_clamp = CW'(count_ff);
      end
   end

   // entry test: base+len, base+size and pointer compare side by side
   assign e_base      = rd_data[W-1:0];
   assign e_len       = rd_data[2*W-1:W];
   assign e_usable    = rd_data[2*W];
   assign e_end       = {1'b0, e_base} + {1'b0, e_len};
   assign e_base_need = {1'b0, e_base} + {1'b0, size_ff};
   assign ptr_ge      = (ptr_ff >= e_base);
   assign fits        = e_usable && (ptr_ge ? (ptr_need_ff <= e_end) : (e_base_need <= e_end));
   assign status.hit  = fits;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.init_ptr) begin
         ptr_in = init_sum & ~(mmba_pkg::PAGE_SIZE - W'(1));
      end else if (cmd.commit && hit_ff) begin
         ptr_in = grant_ff + size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kend_ff  <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         hit_ff   <= 1'b0;
         limit_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mmba_pkg::CSR_KERNEL_END:  kend_ff  <= csr_write_data;
               mmba_pkg::CSR_ENTRY_COUNT: count_ff <= csr_write_data[mmba_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         ptr_ff <= ptr_in;
         if (cmd.latch_req) begin
            hit_ff   <= 1'b0;
            // a size that rounds past the top fails with an empty scan
            limit_ff <= size_sum[W] ? '0 : limit_clamp;
         end else if (cmd.eval && fits) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         size_ff <= size_sum[W-1:0] & ~(mmba_pkg::ALLOC_ALIGN - W'(1));
      end
      ptr_need_ff <= {1'b0, ptr_ff} + {1'b0, size_ff};
      if (cmd.eval && fits) begin
         grant_ff <= ptr_ge ? ptr_ff : e_base;
      end
      if (cmd.commit) begin
         out_addr_ff   <= hit_ff ? grant_ff : '0;
         out_failed_ff <= !hit_ff;
      end
   end

   assign scan_limit        = limit_ff;
   assign rsp_alloc_address = out_addr_ff;
   assign rsp_alloc_failed  = out_failed_ff;

endmodule

[hw/rtl/memory_map_bump_allocator_core.sv]
// Bump allocator over a firmware memory map. Each req word carries an
// opcode: write entry stores base, length and a usable mark (kind 1 with
// attribute bit 0) into a MAP_DEPTH-slot map RAM; init pointer loads the
// free pointer with kernel_end + 4 KiB rounded up to 4 KiB; allocate rounds
// the size up to 64 bytes, walks the first min(map_entry_count, MAP_DEPTH)
// entries in order and grants from the first usable region that fits,
// either at the pointer or at the region start, then bumps the pointer.
// Only allocate returns a rsp word; a miss (or a size that rounds past
// 2^64) reports alloc_failed with address 0 and leaves the pointer alone.
// Write entry and init pointer leave the block idle and ready for the next
// req word. Allocate holds off the next req word from accept until its rsp
// word is loaded, and its scan stops at the first hit. The scan reads one
// map RAM entry per cycle through its single read port. A finished rsp
// word waits in its output register while further write and init words
// are still taken. Map slots are undefined until written, so there is no
// clearing pass after reset; scanning a slot never written is not
// supported. The user must write the CSRs only while the block is idle;
// the block itself does not enforce it.
module memory_map_bump_allocator_core #(
   parameter int MAP_DEPTH = mmba_pkg::MAP_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   mmba_req_if.sink                          req_bus,
   mmba_rsp_if.source                        rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [mmba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mmba_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int CW = $clog2(MAP_DEPTH + 1);

   mmba_pkg::cmd_type    cmd;
   mmba_pkg::status_type status;
   logic [AW-1:0]        rd_addr;
   logic [CW-1:0]        scan_limit;

   // sequencer: handshakes, scan index, result hold
   mmba_ctrl #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_opcode (req_bus.opcode),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .scan_limit (scan_limit),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   // map RAM, pointer, CSRs, fit test, output word
   mmba_dp #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_entry_index       (req_bus.entry_index),
      .req_region_base       (req_bus.region_base),
      .req_region_length     (req_bus.region_length),
      .req_region_kind       (req_bus.region_kind),
      .req_region_attributes (req_bus.region_attributes),
      .req_request_size      (req_bus.request_size),
      .cmd                   (cmd),
      .rd_addr               (rd_addr),
      .status                (status),
      .scan_limit            (scan_limit),
      .rsp_alloc_address     (rsp_bus.alloc_address),
      .rsp_alloc_failed      (rsp_bus.alloc_failed)
   );

endmodule

[hw/rtl/mmba_checker.sv]
module mmba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [mmba_pkg::OPCODE_W-1:0] req_opcode,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mmba_pkg::ADDR_W-1:0]   rsp_alloc_address,
   input logic                          rsp_alloc_failed
);

   // block comes out of reset ready for a word
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

   // an allocate holds off the next req word while it scans
   a_alloc_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == mmba_pkg::OP_ALLOC) |=> !req_ready)
      else $error("req taken during allocate scan");

   // entry writes, pointer init and unused opcodes leave req ready for the next word
   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode != mmba_pkg::OP_ALLOC) |=> req_ready)
      else $error("req stalled after single-cycle op");

   // stalled rsp word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_alloc_address) && $stable(rsp_alloc_failed)))
      else $error("rsp word changed while stalled");

endmodule

bind memory_map_bump_allocator_core mmba_checker u_mmba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_opcode        (req_bus.opcode),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_alloc_address (rsp_bus.alloc_address),
   .rsp_alloc_failed  (rsp_bus.alloc_failed)
);

[sim/mmba_alloc_checker.sv]
`timescale 1ns / 1ps

// Watches the req, rsp and CSR ports, keeps a shadow of the map and the free
// pointer, and checks every rsp word against the oldest predicted allocation.
module mmba_alloc_checker #(
   parameter int MAP_DEPTH = mmba_pkg::MAP_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   mmba_req_if                               req_mon,
   mmba_rsp_if                               rsp_mon,
   input  logic                              csr_write_enable,
   input  logic [mmba_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mmba_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                                alloc_outstanding,
   output int                                grant_count,
   output int                                miss_count,
   output int                                failures
);
   import mmba_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              failed;
   } alloc_word_type;

   logic [ADDR_W-1:0]  map_base   [MAP_DEPTH];
   logic [ADDR_W-1:0]  map_length [MAP_DEPTH];
   logic               map_usable [MAP_DEPTH];
   logic [ADDR_W-1:0]  free_ptr;
   logic [ADDR_W-1:0]  kernel_end;
   logic [COUNT_W-1:0] entry_count;
   alloc_word_type     expected_allocs [$];

   // first usable entry that holds the rounded block; sums kept in 65 bits
   function automatic alloc_word_type grant_block(input logic [ADDR_W-1:0] request);
      logic [ADDR_W:0]   rounded;
      logic [ADDR_W:0]   need;
      logic [ADDR_W:0]   limit;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] place;
      int                scan;
      int                k;
      alloc_word_type    grant;
      rounded = {1'b0, request} + {1'b0, ALLOC_ALIGN - 1};
      size    = rounded[ADDR_W-1:0] & ~(ALLOC_ALIGN - 1);
      scan    = (entry_count > MAP_DEPTH) ? MAP_DEPTH : int'(entry_count);
      grant   = '{address: '0, failed: 1'b1};
      for (k = 0; k < scan && grant.failed && !rounded[ADDR_W]; k++) begin
         if (map_usable[k]) begin
            limit = {1'b0, map_base[k]} + {1'b0, map_length[k]};
            place = (free_ptr >= map_base[k]) ? free_ptr : map_base[k];
            need  = {1'b0, place} + {1'b0, size};
            if (need <= limit) grant = '{address: place, failed: 1'b0};
         end
      end
      if (!grant.failed) free_ptr = grant.address + size;
      return grant;
   endfunction

   always @(posedge clock) begin
      alloc_word_type want;
      int             k;
      if (reset) begin
         for (k = 0; k < MAP_DEPTH; k++) begin
            map_base[k]   = '0;
            map_length[k] = '0;
            map_usable[k] = 1'b0;
         end
         free_ptr    = '0;
         kernel_end  = '0;
         entry_count = '0;
         grant_count = 0;
         miss_count  = 0;
         failures    = 0;
         expected_allocs.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_KERNEL_END:  kernel_end  = csr_write_data;
               CSR_ENTRY_COUNT: entry_count = csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_allocs.size() == 0) begin
               $error("unexpected rsp word: alloc_address %h alloc_failed %b",
                      rsp_mon.alloc_address, rsp_mon.alloc_failed);
               failures++;
            end else begin
               want = expected_allocs.pop_front();
               if (rsp_mon.alloc_address !== want.address) begin
                  $error("alloc_address: expected %h, actual %h",
                         want.address, rsp_mon.alloc_address);
                  failures++;
               end
               if (rsp_mon.alloc_failed !== want.failed) begin
                  $error("alloc_failed: expected %b, actual %b",
                         want.failed, rsp_mon.alloc_failed);
                  failures++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            case (opcode_type'(req_mon.opcode))
               OP_WRITE_ENTRY: begin
                  if (int'(req_mon.entry_index) < MAP_DEPTH) begin
                     map_base[req_mon.entry_index]   = req_mon.region_base;
                     map_length[req_mon.entry_index] = req_mon.region_length;
                     map_usable[req_mon.entry_index] =
                        (req_mon.region_kind == KIND_USABLE) && req_mon.region_attributes[0];
                  end
               end
               OP_INIT_PTR: begin
                  free_ptr = (kernel_end + PAGE_SIZE + (PAGE_SIZE - 1)) & ~(PAGE_SIZE - 1);
               end
               OP_ALLOC: begin
                  want = grant_block(req_mon.request_size);
                  expected_allocs.push_back(want);
                  if (want.failed) miss_count++;
                  else grant_count++;
               end
               default: ;  // spare opcode is dropped
            endcase
         end
      end
      alloc_outstanding <= expected_allocs.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import mmba_pkg::*;

   localparam int MAP_DEPTH    = MAP_DEPTH_DEFAULT;
   localparam int ITEM_TARGET  = 650;
   localparam int PHASES       = 8;
   localparam int STEADY_PHASE = 3;
   // the drain pause leaves room for an allocate to scan up to MAP_DEPTH entries
   localparam int DRAIN_CYCLES = MAP_DEPTH + 8;
   // slowest correct stretch without a handshake: a full scan, a long rsp
   // stall, a sender gap and the drain pause stay well under this limit
   localparam int QUIET_LIMIT  = 4000;
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;  // not decoded by the block
   localparam logic [ADDR_W-1:0]   ALL_ONES = '1;

   typedef struct {
      logic [OPCODE_W-1:0]    opcode;
      logic [ENTRY_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]      start;
      logic [ADDR_W-1:0]      length;
      logic [KIND_W-1:0]      kind;
      logic [ATTR_W-1:0]      attr;
      logic [ADDR_W-1:0]      size;
   } req_word_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   bit                     steady;  // both sides run without idling

   int alloc_outstanding;
   int grant_count;
   int miss_count;
   int failures;

   // stimulus bookkeeping
   bit entry_written [MAP_DEPTH];
   int item_count;
   int write_words;
   int init_words;
   int alloc_words;
   int spare_words;
   int settings;
   int quiet_cycles = 0;

   mmba_req_if req_bus ();
   mmba_rsp_if rsp_bus ();

   memory_map_bump_allocator_core #(
      .MAP_DEPTH (MAP_DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   mmba_alloc_checker #(
      .MAP_DEPTH (MAP_DEPTH)
   ) alloc_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .alloc_outstanding (alloc_outstanding),
      .grant_count       (grant_count),
      .miss_count        (miss_count),
      .failures          (failures)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rsp side: stalls about a third of the cycles unless in the steady phase
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 35);
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("memory_map_bump_allocator_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // all fields random, so unused fields still toggle every bit
   function automatic req_word_type random_fill(input logic [OPCODE_W-1:0] opcode);
      req_word_type w;
      w.opcode = opcode;
      w.slot   = ENTRY_IDX_W'($urandom_range(0, MAP_DEPTH - 1));
      w.start  = rand64();
      w.length = rand64();
      w.kind   = $urandom();
      w.attr   = $urandom();
      w.size   = rand64();
      return w;
   endfunction

   function automatic req_word_type entry_word(input int slot,
                                               input logic [ADDR_W-1:0] start,
                                               input logic [ADDR_W-1:0] length,
                                               input logic [KIND_W-1:0] kind,
                                               input logic [ATTR_W-1:0] attr);
      req_word_type w;
      w        = random_fill(OP_WRITE_ENTRY);
      w.slot   = ENTRY_IDX_W'(slot);
      w.start  = start;
      w.length = length;
      w.kind   = kind;
      w.attr   = attr;
      return w;
   endfunction

   function automatic req_word_type alloc_word(input logic [ADDR_W-1:0] size);
      req_word_type w;
      w      = random_fill(OP_ALLOC);
      w.size = size;
      return w;
   endfunction

   // map entry mostly near the kernel end so allocations land; some near the
   // top of the address space and some fully random
   function automatic req_word_type map_word(input int slot);
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic [KIND_W-1:0] kind;
      logic [ATTR_W-1:0] attr;
      case ($urandom_range(0, 9))
         0: begin
            start  = rand64();
            length = rand64();
         end
         1: begin
            start  = {44'hFFF_FFFF_FFFF, 8'($urandom_range(0, 255)), 12'h000};
            length = ($urandom_range(0, 1) != 0) ? ALL_ONES : rand64();
         end
         default: begin
            start  = 64'($urandom_range(0, 8191)) * PAGE_SIZE;
            length = 64'($urandom_range(0, 2048)) * PAGE_SIZE;
         end
      endcase
      kind = ($urandom_range(0, 3) != 0) ? KIND_USABLE : KIND_W'($urandom());
      attr = ($urandom_range(0, 3) != 0) ? (ATTR_W'($urandom()) | 1) : ATTR_W'($urandom());
      return entry_word(slot, start, length, kind, attr);
   endfunction

   function automatic logic [ADDR_W-1:0] random_size();
      case ($urandom_range(0, 19))
         0:       return rand64();
         1:       return ALL_ONES - 64'($urandom_range(0, 127));
         2:       return '0;
         3:       return 64'($urandom_range(0, 64)) * PAGE_SIZE * 256;
         default: return 64'($urandom_range(0, 9000));
      endcase
   endfunction

   // entries 0..n-1 all written: scan counts up to n are legal
   function automatic int written_prefix();
      int n;
      n = 0;
      while (n < MAP_DEPTH && entry_written[n]) n++;
      return n;
   endfunction

   // one req word; valid drops only on the idle cycles in front of it
   task automatic issue(input req_word_type w);
      while (!steady && $urandom_range(0, 99) < 35) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.opcode            <= w.opcode;
      req_bus.entry_index       <= w.slot;
      req_bus.region_base       <= w.start;
      req_bus.region_length     <= w.length;
      req_bus.region_kind       <= w.kind;
      req_bus.region_attributes <= w.attr;
      req_bus.request_size      <= w.size;
      do @(posedge clock); while (!req_bus.ready);
      case (w.opcode)
         OP_WRITE_ENTRY: begin
            write_words++;
            entry_written[w.slot] = 1'b1;
         end
         OP_INIT_PTR: init_words++;
         OP_ALLOC:    alloc_words++;
         default:     spare_words++;
      endcase
      if (w.opcode != OP_SPARE) item_count++;
   endtask

   // wait for every rsp word, then wait out the drain pause
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (alloc_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both CSRs, back to back; only called while the block is idle
   task automatic program_regs(input logic [ADDR_W-1:0] kernel, input logic [COUNT_W-1:0] count);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_KERNEL_END;
      csr_write_data   <= kernel;
      @(posedge clock);
      csr_index        <= CSR_ENTRY_COUNT;
      csr_write_data   <= CSR_DATA_W'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings++;
   endtask

   initial begin
      int                 phase;
      int                 phase_end;
      int                 pick;
      int                 filled;
      int                 slot;
      logic [ADDR_W-1:0]  kernel;
      logic [COUNT_W-1:0] count;

      reset                     = 1'b1;
      steady                    = 1'b0;
      csr_write_enable          = 1'b0;
      csr_index                 = CSR_KERNEL_END;
      csr_write_data            = '0;
      req_bus.valid             = 1'b0;
      req_bus.opcode            = OP_WRITE_ENTRY;
      req_bus.entry_index       = '0;
      req_bus.region_base       = '0;
      req_bus.region_length     = '0;
      req_bus.region_kind       = '0;
      req_bus.region_attributes = '0;
      req_bus.request_size      = '0;
      rsp_bus.ready             = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty scan: count zero refuses everything
      program_regs('0, '0);
      issue(alloc_word(64'h40));
      issue(random_fill(OP_SPARE));  // spare opcode, nothing happens

      // one usable region, wrong kind, attribute bit 0 clear, one that runs
      // past the top of the address space, and the last slot
      issue(entry_word(0, '0, 64'h10_0000, KIND_USABLE, 32'h1));
      issue(entry_word(1, '0, ALL_ONES, 32'h2, 32'h1));
      issue(entry_word(2, 64'h20_0000, 64'h10_0000, KIND_USABLE, 32'hFFFF_FFFE));
      issue(entry_word(3, 64'hFFFF_FFFF_FFFF_0000, ALL_ONES, KIND_USABLE, 32'hFFFF_FFFF));
      issue(entry_word(MAP_DEPTH - 1, ALL_ONES, '0, 32'hFFFF_FFFF, 32'h0));
      settle();

      program_regs('0, COUNT_W'(4));
      issue(random_fill(OP_INIT_PTR));
      issue(alloc_word('0));                        // zero size, at the pointer
      issue(alloc_word(64'h1));                     // rounds up to 64
      issue(alloc_word(64'h40));
      issue(alloc_word(ALL_ONES));                  // rounding overflow, refused
      issue(alloc_word(64'hFFFF_FFFF_FFFF_FFC0));   // largest size that rounds
      issue(alloc_word(64'h10_0000));
      issue(alloc_word(64'h2_0000));
      settle();

      // pointer load wraps; a jump to the top region pushes the pointer past 2^64
      program_regs(ALL_ONES, COUNT_W'(4));
      issue(random_fill(OP_INIT_PTR));
      issue(alloc_word(64'h20_0000));
      issue(alloc_word(64'h40));
      settle();

      program_regs(64'hFF_EFFF, COUNT_W'(2));
      issue(random_fill(OP_INIT_PTR));
      issue(alloc_word(64'h100));
      settle();

      // ---- random part: phases of init then mixed words ----
      for (phase = 0; phase < PHASES; phase++) begin
         filled = written_prefix();
         case ($urandom_range(0, 9))
            0:       kernel = '0;
            1:       kernel = ALL_ONES;
            2:       kernel = rand64();
            default: kernel = 64'($urandom_range(0, 24'hFF_FFFF));
         endcase
         if (phase == PHASES - 1) begin
            count = (filled == MAP_DEPTH) ? COUNT_W'($urandom_range(MAP_DEPTH + 1, 63))
                                          : COUNT_W'(filled);
         end else if (phase == 0) begin
            count = COUNT_W'(filled);
         end else begin
            count = COUNT_W'($urandom_range(0, filled));
         end
         program_regs(kernel, count);
         steady = (phase == STEADY_PHASE);

         phase_end = item_count + (ITEM_TARGET - item_count) / (PHASES - phase);
         issue(random_fill(OP_INIT_PTR));
         while (item_count < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               issue(random_fill(OP_SPARE));
            end else if (pick < 7) begin
               issue(random_fill(OP_INIT_PTR));
            end else if (pick < 32) begin
               filled = written_prefix();
               slot = (filled < MAP_DEPTH && $urandom_range(0, 1) != 0)
                      ? filled : $urandom_range(0, MAP_DEPTH - 1);
               issue(map_word(slot));
            end else begin
               issue(alloc_word(random_size()));
            end
         end
         steady = 1'b0;
         settle();
      end

      $display("covered %0d map writes, %0d pointer loads, %0d spare-opcode words",
               write_words, init_words, spare_words);
      $display("and %0d allocations (%0d granted, %0d refused) over %0d register settings",
               alloc_words, grant_count, miss_count, settings);
      if (failures == 0 && alloc_outstanding == 0) begin
         $display("memory_map_bump_allocator_core verification clean");
      end else begin
         $display("memory_map_bump_allocator_core verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/mmba_pkg.sv
hw/rtl/mmba_if.sv
hw/rtl/mmba_ram.sv
hw/rtl/mmba_ctrl.sv
hw/rtl/mmba_dp.sv
hw/rtl/memory_map_bump_allocator_core.sv
hw/rtl/mmba_checker.sv
sim/mmba_alloc_checker.sv
sim/tb_top.sv
